// ----- hw/rtl/mat4_vector_transform_assert.svh -----
// Assertion macros for the 4x4 matrix-vector transform.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef MAT4_VECTOR_TRANSFORM_ASSERT_SVH
`define MAT4_VECTOR_TRANSFORM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mvt_pkg.sv -----
// Shared types and constants for the 4x4 matrix-vector transform.
// No dependencies.
package mvt_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned VEC_LEN   = 4;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_XFORM = 1'b1
  } kind_e;

  // per-cycle controls shared by all lanes
  typedef struct packed {
    logic wr;     // load item accepted: write one element
    logic s1_en;  // product stage advances
    logic s2_en;  // sum/saturate stage advances
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/mvt_if.sv -----
// Channel interfaces for the 4x4 matrix-vector transform.
// Depends on nothing; payload width set by DATA_WIDTH.
interface mvt_in_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic        [3:0]            elem_index;
  logic signed [DATA_WIDTH-1:0] elem_value;
  logic signed [DATA_WIDTH-1:0] vec_x;
  logic signed [DATA_WIDTH-1:0] vec_y;
  logic signed [DATA_WIDTH-1:0] vec_z;
  logic signed [DATA_WIDTH-1:0] vec_w;

  modport source (
    output valid, kind, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, kind, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

interface mvt_out_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_x;
  logic signed [DATA_WIDTH-1:0] res_y;
  logic signed [DATA_WIDTH-1:0] res_z;
  logic signed [DATA_WIDTH-1:0] res_w;

  modport source (
    output valid, res_x, res_y, res_z, res_w,
    input  ready
  );
  modport sink (
    input  valid, res_x, res_y, res_z, res_w,
    output ready
  );
endinterface

// ----- hw/rtl/mvt_lane.sv -----
// One matrix row: its four stored elements, four multipliers, then the
// sum, shift and saturation. Depends on mvt_pkg.
module mvt_lane import mvt_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned LANE_ID    = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lane_ctrl_t                   ctrl_i,
  input  logic        [3:0]            wr_index_i,
  input  logic signed [DATA_WIDTH-1:0] wr_data_i,
  input  logic signed [DATA_WIDTH-1:0] vec_i [VEC_LEN],
  output logic signed [DATA_WIDTH-1:0] res_o
);

  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam logic [1:0]  ROW_SEL = 2'(LANE_ID);
  localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0] row_q  [VEC_LEN];
  logic signed [PROD_W-1:0]     prod_d [VEC_LEN];
  logic signed [PROD_W-1:0]     prod_q [VEC_LEN];
  logic signed [SUM_W-1:0]      sum;
  logic signed [SUM_W-1:0]      shifted;
  logic        [SUM_W-DATA_WIDTH:0] high_bits;
  logic signed [DATA_WIDTH-1:0] res_d;
  logic signed [DATA_WIDTH-1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VEC_LEN; k++) row_q[k] <= '0;
    end else if (ctrl_i.wr && wr_index_i[3:2] == ROW_SEL) begin
      row_q[wr_index_i[1:0]] <= wr_data_i;
    end
  end

  always_comb begin
    for (int k = 0; k < VEC_LEN; k++) prod_d[k] = row_q[k] * vec_i[k];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      for (int k = 0; k < VEC_LEN; k++) prod_q[k] <= prod_d[k];
    end
  end

  // exact sum, floor shift, then clamp to the data width
  always_comb begin
    sum = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]);
    shifted   = sum >>> FRAC_BITS;
    high_bits = shifted[SUM_W-1:DATA_WIDTH-1];
    if (high_bits == '0 || high_bits == '1) begin
      res_d = shifted[DATA_WIDTH-1:0];
    end else if (shifted[SUM_W-1]) begin
      res_d = MIN_VAL;
    end else begin
      res_d = MAX_VAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_en) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- hw/rtl/mvt_merge.sv -----
// Output stage: gathers the four lane results into one item and holds it
// until taken. Depends on mvt_pkg and mvt_out_if.
module mvt_merge import mvt_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_en_i,
  input  logic                         s2_valid_i,
  input  logic signed [DATA_WIDTH-1:0] lane_res_i [NUM_LANES],
  mvt_out_if.source                    out_o
);

  logic                         valid_q;
  logic signed [DATA_WIDTH-1:0] res_q [NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_en_i) begin
      valid_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i && s2_valid_i) begin
      for (int i = 0; i < NUM_LANES; i++) res_q[i] <= lane_res_i[i];
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.res_x = res_q[0];
  assign out_o.res_y = res_q[1];
  assign out_o.res_z = res_q[2];
  assign out_o.res_w = res_q[3];

endmodule

// ----- hw/rtl/mat4_vector_transform.sv -----
// Throughput is one item per cycle, loads and transforms alike, while the output
// is not held back; a transform's result passes through the product register, the
// sum and saturate register and the output register, and each stage stalls only
// when the one after it is full and not draining. A load takes effect for every
// transform accepted after it. Depends on mvt_pkg, mvt_if, mvt_lane and mvt_merge.
module mat4_vector_transform import mvt_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvt_in_if.sink    in_i,
  mvt_out_if.source out_o
);

`include "mat4_vector_transform_assert.svh"

  logic       s1_valid_q, s2_valid_q;
  logic       out_en, s2_en, s1_en;
  logic       in_acc;
  lane_ctrl_t ctrl;

  logic signed [DATA_WIDTH-1:0] vec      [VEC_LEN];
  logic signed [DATA_WIDTH-1:0] lane_res [NUM_LANES];

  assign out_en = !out_o.valid || out_o.ready;
  assign s2_en  = !s2_valid_q || out_en;
  assign s1_en  = !s1_valid_q || s2_en;

  assign in_i.ready = s1_en;
  assign in_acc     = in_i.valid && s1_en;

  assign ctrl.wr    = in_acc && (in_i.kind == KIND_LOAD);
  assign ctrl.s1_en = s1_en;
  assign ctrl.s2_en = s2_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_acc && (in_i.kind == KIND_XFORM);
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  assign vec[0] = in_i.vec_x;
  assign vec[1] = in_i.vec_y;
  assign vec[2] = in_i.vec_z;
  assign vec[3] = in_i.vec_w;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mvt_lane #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS),
      .LANE_ID   (g)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_index_i(in_i.elem_index),
      .wr_data_i (in_i.elem_value),
      .vec_i     (vec),
      .res_o     (lane_res[g])
    );
  end

  mvt_merge #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_en_i (out_en),
    .s2_valid_i(s2_valid_q),
    .lane_res_i(lane_res),
    .out_o     (out_o)
  );

  `MVT_ASSERT_NOW(a_no_overrun, out_o.valid && !out_o.ready && s1_valid_q && s2_valid_q, !in_i.ready, "input taken while pipeline full")
  `MVT_ASSERT_NEXT(a_load_no_result, in_acc && in_i.kind == KIND_LOAD, !s1_valid_q, "load item started a result")
  `MVT_ASSERT_NEXT(a_xform_enters, in_acc && in_i.kind == KIND_XFORM, s1_valid_q, "transform item lost at entry")
  `MVT_ASSERT_NEXT(a_result_lands, s2_valid_q && out_en, out_o.valid, "finished result not presented")

endmodule
